FILE: rtl/core/sukt_pkg.sv
// Shared types and constants for the sorted unique key table.
`default_nettype none

package sukt_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int DEFAULT_KEY_BITS = 32;
    localparam int RANK_BITS        = 6;
    localparam int OPCODE_BITS      = 3;
    localparam int STATUS_BITS      = 3;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_UPDATE = 3'd2,
        OP_FIND   = 3'd3,
        OP_READ   = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_EXEC,
        S_CMP2,
        S_EXEC2
    } state_t;

    // Command broadcast to every cell
    typedef enum logic [1:0] {
        CC_HOLD,
        CC_CMP,
        CC_INS,
        CC_DEL
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t            cmd;
        logic [RANK_BITS-1:0] rank;
    } cell_ctrl_t;

    // Registered compare results of one cell
    typedef struct packed {
        logic eq;   // valid entry equal to the key
        logic lt;   // key below entry, or entry empty
        logic ge;   // valid entry at or above the key
        logic hit;  // cell index equals requested rank
    } cell_flag_t;

endpackage

`default_nettype wire

FILE: rtl/core/sukt_cell.sv
// One slot of the sorted table: holds a key, compares, shifts with its neighbors.
`default_nettype none

module sukt_cell
    import sukt_pkg::*;
#(
    parameter int IDX      = 0,
    parameter int KEY_BITS = DEFAULT_KEY_BITS,
    parameter int COUNT_W  = 7
)
(
    input  wire logic                clk,
    input  wire cell_ctrl_t          ctrl,
    input  wire logic [KEY_BITS-1:0] bcast_key,
    input  wire logic [COUNT_W-1:0]  count,
    input  wire logic [KEY_BITS-1:0] left_key,
    input  wire logic                left_lt,
    input  wire logic [KEY_BITS-1:0] right_key,
    output logic      [KEY_BITS-1:0] key_q,
    output cell_flag_t               flag_q
);

    localparam int CMPW = (COUNT_W > RANK_BITS) ? COUNT_W : RANK_BITS;

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    cell_flag_t          flag_reg;
    cell_flag_t          flag_next;
    logic                valid;
    logic [CMPW-1:0]     rank_ext;

    assign valid    = COUNT_W'(IDX) < count;
    assign rank_ext = CMPW'(ctrl.rank);

    // compare and shift
    always_comb
    begin
        key_next  = key_reg;
        flag_next = flag_reg;
        case (ctrl.cmd)
            CC_CMP:
            begin
                flag_next.eq  = valid && (key_reg == bcast_key);
                flag_next.lt  = !valid || ($signed(bcast_key) < $signed(key_reg));
                flag_next.ge  = valid && !($signed(key_reg) < $signed(bcast_key));
                flag_next.hit = (rank_ext == CMPW'(IDX));
            end
            CC_INS:
            begin
                // entries above the new key move up one slot
                if (flag_reg.lt)
                begin
                    key_next = left_lt ? left_key : bcast_key;
                end
            end
            CC_DEL:
            begin
                // entries at or above the removed key move down one slot
                if (flag_reg.ge)
                begin
                    key_next = right_key;
                end
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        flag_reg <= flag_next;
    end

    assign key_q  = key_reg;
    assign flag_q = flag_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sorted_unique_key_table.sv
// Top level of the sorted unique key table: control sequencer and row of cells.
//
// Usage: one input beat (opcode, key, new_value, rank) gives one result beat
// (status, found, entry_count, read_value). Both channels use valid/stall; a
// beat moves when valid is high and stall is low.
// Each slot of the table is a cell that compares its key to a broadcast key
// and shifts to a neighbor on insert or delete, so the whole table moves at
// once. An item passes through a compare state and an execute state; the
// result is registered at the end of execute. The next item is accepted
// during execute, while the last one is still finishing; an update whose key
// is found does a delete pass and an insert pass, and takes the next item
// during its second execute.
// When the receiver stalls, the finished result stays in the output register;
// the next item may still be taken, and it waits in its compare state until
// the output register is free.
// Reset empties the table (count goes to zero) and clears out_valid; entry
// contents are not cleared and are never read before being written.
`default_nettype none

module sorted_unique_key_table
    import sukt_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    parameter int KEY_BITS = DEFAULT_KEY_BITS
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [OPCODE_BITS-1:0]     opcode,
    input  wire logic signed [KEY_BITS-1:0] key,
    input  wire logic signed [KEY_BITS-1:0] new_value,
    input  wire logic [RANK_BITS-1:0]       rank,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [STATUS_BITS-1:0]          status,
    output logic                            found,
    output logic [$clog2(CAPACITY+1)-1:0]   entry_count,
    output logic signed [KEY_BITS-1:0]      read_value
);

    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int CMPW    = (COUNT_W > RANK_BITS) ? COUNT_W : RANK_BITS;

    // sequencer state
    state_t state_reg, state_next;

    // latched item
    logic [OPCODE_BITS-1:0] op_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [KEY_BITS-1:0]    nv_reg;
    logic [RANK_BITS-1:0]   rank_reg;

    logic [COUNT_W-1:0] count_reg, count_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_BITS-1:0] status_reg, status_next;
    logic                   found_reg, found_next;
    logic [COUNT_W-1:0]     ecount_reg, ecount_next;
    logic [KEY_BITS-1:0]    rv_reg, rv_next;

    logic in_accept;
    logic slot_free;
    logic produce;

    // cell row
    cell_ctrl_t          ctrl;
    logic [KEY_BITS-1:0] bcast_key;
    logic [KEY_BITS-1:0] cell_key  [CAPACITY];
    cell_flag_t          cell_flag [CAPACITY];
    logic                found_any;
    logic [KEY_BITS-1:0] read_or;

    assign in_accept = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [KEY_BITS-1:0] lk;
            logic                llt;
            logic [KEY_BITS-1:0] rk;
            if (i == 0)
            begin : g_first
                assign lk  = cell_key[i];
                assign llt = 1'b0;
            end
            else
            begin : g_mid
                assign lk  = cell_key[i-1];
                assign llt = cell_flag[i-1].lt;
            end
            if (i == CAPACITY - 1)
            begin : g_last
                assign rk = cell_key[i];
            end
            else
            begin : g_body
                assign rk = cell_key[i+1];
            end
            sukt_cell #(
                .IDX      (i),
                .KEY_BITS (KEY_BITS),
                .COUNT_W  (COUNT_W)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .bcast_key (bcast_key),
                .count     (count_reg),
                .left_key  (lk),
                .left_lt   (llt),
                .right_key (rk),
                .key_q     (cell_key[i]),
                .flag_q    (cell_flag[i])
            );
        end
    endgenerate

    // presence and rank read over the row
    always_comb
    begin
        found_any = 1'b0;
        read_or   = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            found_any = found_any | cell_flag[i].eq;
            read_or   = read_or | (cell_key[i] & {KEY_BITS{cell_flag[i].hit}});
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (slot_free)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (op_reg == OP_UPDATE && found_any)
                begin
                    state_next = S_CMP2;
                end
                else if (in_valid)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_CMP2:
            begin
                if (slot_free)
                begin
                    state_next = S_EXEC2;
                end
            end
            S_EXEC2:
            begin
                state_next = in_valid ? S_CMP : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall    = 1'b1;
        ctrl.cmd    = CC_HOLD;
        ctrl.rank   = rank_reg;
        bcast_key   = key_reg;
        count_next  = count_reg;
        produce     = 1'b0;
        status_next = ST_OK;
        found_next  = 1'b0;
        rv_next     = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
            end
            S_CMP:
            begin
                ctrl.cmd = CC_CMP;
            end
            S_EXEC:
            begin
                in_stall = (op_reg == OP_UPDATE) && found_any;
                produce  = 1'b1;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (found_any)
                        begin
                            status_next = ST_DUPLICATE;
                            found_next  = 1'b1;
                        end
                        else if (count_reg == COUNT_W'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ctrl.cmd   = CC_INS;
                            count_next = count_reg + COUNT_W'(1);
                        end
                    end
                    OP_DELETE:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else if (found_any)
                        begin
                            found_next = 1'b1;
                            ctrl.cmd   = CC_DEL;
                            count_next = count_reg - COUNT_W'(1);
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    OP_UPDATE:
                    begin
                        if (found_any)
                        begin
                            // result comes after the insert pass
                            produce    = 1'b0;
                            ctrl.cmd   = CC_DEL;
                            count_next = count_reg - COUNT_W'(1);
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    OP_FIND:
                    begin
                        if (found_any)
                        begin
                            found_next = 1'b1;
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    OP_READ:
                    begin
                        if (CMPW'(rank_reg) < CMPW'(count_reg))
                        begin
                            rv_next = read_or;
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end
            S_CMP2:
            begin
                ctrl.cmd  = CC_CMP;
                bcast_key = nv_reg;
            end
            S_EXEC2:
            begin
                in_stall   = 1'b0;
                ctrl.cmd   = CC_INS;
                bcast_key  = nv_reg;
                count_next = count_reg + COUNT_W'(1);
                produce    = 1'b1;
                found_next = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // output slot
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        ecount_next    = count_next;
        if (produce)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg   <= opcode;
            key_reg  <= key;
            nv_reg   <= new_value;
            rank_reg <= rank;
        end
        if (produce)
        begin
            status_reg <= status_next;
            found_reg  <= found_next;
            ecount_reg <= ecount_next;
            rv_reg     <= rv_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign entry_count = ecount_reg;
    assign read_value  = rv_reg;

`ifndef SYNTHESIS
    // table never holds more than its capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // execute only starts with the output slot empty
    a_exec_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC || state_reg == S_EXEC2) |-> !out_valid_reg)
        else $error("execute with output slot occupied");

    // second compare pass only follows an update delete pass
    a_cmp2_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_CMP2) |-> $past(state_reg) == S_EXEC
            && $past(op_reg) == OP_UPDATE)
        else $error("second compare without update");

    // a full report means the table was full
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_FULL) |-> ecount_reg == COUNT_W'(CAPACITY))
        else $error("full status with spare room");
`endif

endmodule

`default_nettype wire
